### hdl/gipd_pkg.sv
// Shared types, constants and field tables of the navigation page decoder.
`default_nettype none
package gipd_pkg;

  localparam int PAGE_WORDS  = 8;
  localparam int PARAM_COUNT = 30;
  localparam int IOD_BASE    = 30;
  localparam int RAM_DEPTH   = 34;
  localparam int RAM_AW      = 6;
  localparam int CRC_BITS    = 200;
  localparam logic [23:0] CRC_POLY = 24'h864CFB;
  localparam logic [5:0]  ALL_TYPES = 6'h3F;
  localparam int HALF_WEEK_S = 302400;
  localparam int WEEK_ROLL   = 1024;

  // Status codes of the first result of a page.
  localparam logic [2:0] ST_ALERT    = 3'd0;
  localparam logic [2:0] ST_EVEN_ODD = 3'd1;
  localparam logic [2:0] ST_CRC      = 3'd2;
  localparam logic [2:0] ST_UNUSED   = 3'd3;
  localparam logic [2:0] ST_SVID     = 3'd4;
  localparam logic [2:0] ST_STORED   = 3'd5;
  localparam logic [2:0] ST_IOD      = 3'd6;
  localparam logic [2:0] ST_COMPLETE = 3'd7;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CRC   = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_WRF   = 10'b0000001000,
    S_WRIOD = 10'b0000010000,
    S_IODRD = 10'b0000100000,
    S_RDWK  = 10'b0001000000,
    S_STAT  = 10'b0010000000,
    S_PRD   = 10'b0100000000,
    S_PWT   = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic [2:0] wtype;
    logic [5:0] len;
    logic       sgn;
  } field_desc_t;

  // Word type, length and signedness of each parameter.
  function automatic field_desc_t field_desc(input logic [4:0] p);
    field_desc_t d;
    d = '{wtype: 3'd0, len: 6'd1, sgn: 1'b0};
    case (p)
      5'd0:  d = '{3'd0, 6'd12, 1'b0};
      5'd1:  d = '{3'd0, 6'd20, 1'b0};
      5'd2:  d = '{3'd0, 6'd2,  1'b0};
      5'd3:  d = '{3'd1, 6'd10, 1'b0};
      5'd4:  d = '{3'd1, 6'd14, 1'b0};
      5'd5:  d = '{3'd1, 6'd32, 1'b1};
      5'd6:  d = '{3'd1, 6'd32, 1'b0};
      5'd7:  d = '{3'd1, 6'd32, 1'b0};
      5'd8:  d = '{3'd2, 6'd32, 1'b1};
      5'd9:  d = '{3'd2, 6'd32, 1'b1};
      5'd10: d = '{3'd2, 6'd32, 1'b1};
      5'd11: d = '{3'd2, 6'd14, 1'b1};
      5'd12: d = '{3'd3, 6'd24, 1'b1};
      5'd13: d = '{3'd3, 6'd16, 1'b1};
      5'd14: d = '{3'd3, 6'd16, 1'b1};
      5'd15: d = '{3'd3, 6'd16, 1'b1};
      5'd16: d = '{3'd3, 6'd16, 1'b1};
      5'd17: d = '{3'd3, 6'd16, 1'b1};
      5'd18: d = '{3'd4, 6'd16, 1'b1};
      5'd19: d = '{3'd4, 6'd16, 1'b1};
      5'd20: d = '{3'd4, 6'd14, 1'b0};
      5'd21: d = '{3'd4, 6'd31, 1'b1};
      5'd22: d = '{3'd4, 6'd21, 1'b1};
      5'd23: d = '{3'd4, 6'd6,  1'b1};
      5'd24: d = '{3'd5, 6'd10, 1'b1};
      5'd25: d = '{3'd5, 6'd10, 1'b1};
      5'd26: d = '{3'd5, 6'd2,  1'b0};
      5'd27: d = '{3'd5, 6'd2,  1'b0};
      5'd28: d = '{3'd5, 6'd1,  1'b0};
      5'd29: d = '{3'd5, 6'd1,  1'b0};
      default: d = '{3'd7, 6'd1, 1'b0};
    endcase
    return d;
  endfunction

  // Raw field of a parameter; datr[127 - d] holds data bit d.
  function automatic logic [31:0] raw_field(input logic [127:0] datr, input logic [4:0] p);
    logic [31:0] v;
    v = '0;
    case (p)
      5'd0:  v = 32'(datr[127 - 96 -: 12]);
      5'd1:  v = 32'(datr[127 - 108 -: 20]);
      5'd2:  v = 32'(datr[127 - 6 -: 2]);
      5'd3:  v = 32'(datr[127 - 6 -: 10]);
      5'd4:  v = 32'(datr[127 - 16 -: 14]);
      5'd5:  v = datr[127 - 30 -: 32];
      5'd6:  v = datr[127 - 62 -: 32];
      5'd7:  v = datr[127 - 94 -: 32];
      5'd8:  v = datr[127 - 16 -: 32];
      5'd9:  v = datr[127 - 48 -: 32];
      5'd10: v = datr[127 - 80 -: 32];
      5'd11: v = 32'(datr[127 - 112 -: 14]);
      5'd12: v = 32'(datr[127 - 16 -: 24]);
      5'd13: v = 32'(datr[127 - 40 -: 16]);
      5'd14: v = 32'(datr[127 - 56 -: 16]);
      5'd15: v = 32'(datr[127 - 72 -: 16]);
      5'd16: v = 32'(datr[127 - 88 -: 16]);
      5'd17: v = 32'(datr[127 - 104 -: 16]);
      5'd18: v = 32'(datr[127 - 22 -: 16]);
      5'd19: v = 32'(datr[127 - 38 -: 16]);
      5'd20: v = 32'(datr[127 - 54 -: 14]);
      5'd21: v = 32'(datr[127 - 68 -: 31]);
      5'd22: v = 32'(datr[127 - 99 -: 21]);
      5'd23: v = 32'(datr[127 - 120 -: 6]);
      5'd24: v = 32'(datr[127 - 47 -: 10]);
      5'd25: v = 32'(datr[127 - 57 -: 10]);
      5'd26: v = 32'(datr[127 - 67 -: 2]);
      5'd27: v = 32'(datr[127 - 69 -: 2]);
      5'd28: v = 32'(datr[127 - 71 -: 1]);
      5'd29: v = 32'(datr[127 - 72 -: 1]);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/gnss_inav_page_decoder.sv
// Top level of the navigation page-pair decoder: buffer, CRC, field store and result sequencer.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/stall   | in_word_index, in_page_word
//   out_    | output    | out_valid/stall  | status, page_type, param_valid/id/value, last
//   cfg_    | input     | cfg_wr_en        | cfg_wr_data (satellite id)
//
// Words 0 to 6 are stored in the page buffer. Word 7 starts a decode: a bit-serial CRC over
// 200 bits, then for a good page field writes to the parameter RAM, issue-of-data reads on a
// complete set, then a status result and one result per parameter through the RAM read port.
// Reset is synchronous and clears the control state, the satellite id and the collected-type record.
// A stall on the output holds the result register; input is stalled while a decode runs.
`default_nettype none
module gnss_inav_page_decoder
  import gipd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_word_index,
  input  wire logic [31:0]        in_page_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic [5:0]              out_page_type,
  output logic                    out_param_valid,
  output logic [4:0]              out_param_id,
  output logic signed [32:0]      out_param_value,
  output logic                    out_last,
  input  wire logic               cfg_wr_en,
  input  wire logic [5:0]         cfg_wr_data
);

  state_t state_r, state_nxt;
  logic [31:0] buf_r [PAGE_WORDS];
  logic [5:0]  sat_id_r;
  logic [5:0]  coll_r, coll_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [23:0] crc_r, crc_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [5:0]  type_r, type_nxt;
  logic [9:0]  iod0_r, iod0_nxt;
  logic        mism_r, mism_nxt;
  logic [31:0] toe_r, toe_nxt, tow_r, tow_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [5:0]  o_type_r, o_type_nxt;
  logic        o_pv_r, o_pv_nxt;
  logic [4:0]  o_id_r, o_id_nxt;
  logic signed [32:0] o_val_r, o_val_nxt;
  logic        o_last_r, o_last_nxt;

  logic [255:0] strm;
  logic [127:0] datr;
  logic [23:0]  crc_rx;
  logic         in_take, out_free, crc_bit, crc_top;
  logic [5:0]   dtype;

  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_wa, ram_ra;
  logic [31:0]       ram_wd, ram_rd;

  field_desc_t       fd;
  logic [19:0]       toe60;
  logic signed [22:0] dt;
  logic signed [32:0] pval;
  logic [4:0]        pidx;

  gipd_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // Serial bit view of the page pair and the 128 data bits.
  always_comb begin
    for (int w = 0; w < PAGE_WORDS; w++) begin
      for (int b = 0; b < 32; b++) begin
        strm[w*32 + b] = buf_r[w][31-b];
      end
    end
    for (int d = 0; d < 128; d++) begin
      datr[127-d] = (d < 112) ? strm[d + 2] : strm[d + 18];
    end
    for (int k = 0; k < 24; k++) begin
      crc_rx[23-k] = strm[210 + k];
    end
  end

  assign dtype    = datr[127 -: 6];
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pidx     = cnt_r[4:0];
  assign fd       = field_desc(pidx);

  // CRC input bit: four zero bits, 114 even bits, 82 odd bits.
  always_comb begin
    if (cnt_r < 8'd4) begin
      crc_bit = 1'b0;
    end else if (cnt_r < 8'd118) begin
      crc_bit = strm[cnt_r - 8'd4];
    end else begin
      crc_bit = strm[cnt_r + 8'd10];
    end
    crc_top = crc_r[23] ^ crc_bit;
  end

  // Parameter value with sign extension and the week adjustment.
  always_comb begin
    toe60 = 20'(toe_r[13:0]) * 20'd60;
    dt    = $signed({3'b0, toe60}) - $signed({3'b0, tow_r[19:0]});
    if (pidx == 5'd0) begin
      pval = $signed(33'(ram_rd[11:0]) + 33'(WEEK_ROLL));
      if (dt > 23'sd302400) begin
        pval = pval - 33'sd1;
      end else if (dt < -23'sd302400) begin
        pval = pval + 33'sd1;
      end
    end else if (fd.sgn && ram_rd[5'(fd.len - 6'd1)]) begin
      pval = $signed({1'b0, ram_rd} - (33'd1 << fd.len));
    end else begin
      pval = $signed({1'b0, ram_rd});
    end
  end

  // Decode sequencer.
  always_comb begin
    state_nxt = state_r;
    coll_nxt  = coll_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    st_nxt    = st_r;
    type_nxt  = type_r;
    iod0_nxt  = iod0_r;
    mism_nxt  = mism_r;
    toe_nxt   = toe_r;
    tow_nxt   = tow_r;
    ram_we    = 1'b0;
    ram_wa    = RAM_AW'(pidx);
    ram_wd    = raw_field(datr, pidx);
    ram_re    = 1'b0;
    ram_ra    = RAM_AW'(pidx);
    out_valid_nxt = out_valid_r && out_stall;
    o_status_nxt  = o_status_r;
    o_type_nxt    = o_type_r;
    o_pv_nxt      = o_pv_r;
    o_id_nxt      = o_id_r;
    o_val_nxt     = o_val_r;
    o_last_nxt    = o_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take && in_word_index == 3'd7) begin
          state_nxt = S_CRC;
          cnt_nxt   = '0;
          crc_nxt   = '0;
        end
      end
      S_CRC: begin
        crc_nxt = {crc_r[22:0], 1'b0} ^ (crc_top ? CRC_POLY : 24'd0);
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'(CRC_BITS - 1)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cnt_nxt  = '0;
        type_nxt = '0;
        if (strm[1] || strm[129]) begin
          st_nxt    = ST_ALERT;
          state_nxt = S_STAT;
        end else if (strm[0] || !strm[128]) begin
          st_nxt    = ST_EVEN_ODD;
          state_nxt = S_STAT;
        end else if (crc_r != crc_rx) begin
          st_nxt    = ST_CRC;
          state_nxt = S_STAT;
        end else if (dtype > 6'd5) begin
          st_nxt    = ST_UNUSED;
          type_nxt  = dtype;
          state_nxt = S_STAT;
        end else begin
          type_nxt  = dtype;
          state_nxt = S_WRF;
          if (dtype == 6'd2) begin
            coll_nxt = '0;
          end
        end
      end
      S_WRF: begin
        // One parameter slot per cycle; only those of this word type are written.
        ram_we  = (6'(fd.wtype) == type_r);
        cnt_nxt = cnt_r + 8'd1;
        if (pidx == 5'(PARAM_COUNT - 1)) begin
          state_nxt = S_WRIOD;
        end
      end
      S_WRIOD: begin
        ram_we  = (type_r >= 6'd1) && (type_r <= 6'd4);
        ram_wa  = RAM_AW'(IOD_BASE) + RAM_AW'(type_r - 6'd1);
        ram_wd  = 32'(datr[121 -: 10]);
        cnt_nxt = '0;
        mism_nxt = 1'b0;
        if (type_r == 6'd4 && datr[111 -: 6] != sat_id_r) begin
          st_nxt    = ST_SVID;
          state_nxt = S_STAT;
        end else begin
          coll_nxt = coll_r | (6'd1 << type_r);
          if ((coll_r | (6'd1 << type_r)) != ALL_TYPES) begin
            st_nxt    = ST_STORED;
            state_nxt = S_STAT;
          end else begin
            state_nxt = S_IODRD;
          end
        end
      end
      S_IODRD: begin
        // Read the four issue-of-data entries and compare them with the first.
        ram_re  = (cnt_r < 8'd4);
        ram_ra  = RAM_AW'(IOD_BASE) + RAM_AW'(cnt_r[1:0]);
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'd1) begin
          iod0_nxt = ram_rd[9:0];
        end else if (cnt_r >= 8'd2 && ram_rd[9:0] != iod0_r) begin
          mism_nxt = 1'b1;
        end
        if (cnt_r == 8'd4) begin
          cnt_nxt = '0;
          if (mism_nxt) begin
            st_nxt    = ST_IOD;
            state_nxt = S_STAT;
          end else begin
            st_nxt    = ST_COMPLETE;
            state_nxt = S_RDWK;
          end
        end
      end
      S_RDWK: begin
        // Fetch toe and tow for the week correction.
        cnt_nxt = cnt_r + 8'd1;
        ram_re  = (cnt_r < 8'd2);
        ram_ra  = (cnt_r == 8'd0) ? RAM_AW'(4) : RAM_AW'(1);
        if (cnt_r == 8'd1) begin
          toe_nxt = ram_rd;
        end
        if (cnt_r == 8'd2) begin
          tow_nxt   = ram_rd;
          cnt_nxt   = '0;
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = st_r;
          o_type_nxt    = type_r;
          o_pv_nxt      = 1'b0;
          o_id_nxt      = '0;
          o_val_nxt     = '0;
          o_last_nxt    = (st_r != ST_COMPLETE);
          cnt_nxt       = '0;
          state_nxt     = (st_r == ST_COMPLETE) ? S_PRD : S_IDLE;
        end
      end
      S_PRD: begin
        ram_re    = 1'b1;
        state_nxt = S_PWT;
      end
      S_PWT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = st_r;
          o_type_nxt    = type_r;
          o_pv_nxt      = 1'b1;
          o_id_nxt      = pidx;
          o_val_nxt     = pval;
          o_last_nxt    = (pidx == 5'(PARAM_COUNT - 1));
          cnt_nxt       = cnt_r + 8'd1;
          state_nxt     = (pidx == 5'(PARAM_COUNT - 1)) ? S_IDLE : S_PRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      coll_r      <= '0;
      sat_id_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      coll_r      <= coll_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr_en) begin
        sat_id_r <= cfg_wr_data;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      buf_r[in_word_index] <= in_page_word;
    end
    crc_r      <= crc_nxt;
    st_r       <= st_nxt;
    type_r     <= type_nxt;
    iod0_r     <= iod0_nxt;
    mism_r     <= mism_nxt;
    toe_r      <= toe_nxt;
    tow_r      <= tow_nxt;
    o_status_r <= o_status_nxt;
    o_type_r   <= o_type_nxt;
    o_pv_r     <= o_pv_nxt;
    o_id_r     <= o_id_nxt;
    o_val_r    <= o_val_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_page_type   = o_type_r;
  assign out_param_valid = o_pv_r;
  assign out_param_id    = o_id_r;
  assign out_param_value = o_val_r;
  assign out_last        = o_last_r;

endmodule
`default_nettype wire

### hdl/gipd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module gipd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 34
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### test/gnss_inav_page_decoder_test.sv
// Self-checking testbench of the navigation page-pair decoder with its own page decode predictor.
`default_nettype none
module gnss_inav_page_decoder_test;
  import gipd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 400;

  typedef struct {
    logic [2:0]         status;
    logic [5:0]         page_type;
    logic               param_valid;
    logic [4:0]         param_id;
    logic signed [32:0] param_value;
    logic               last;
  } nav_result_t;

  typedef struct {
    logic [2:0]  word_index;
    logic [31:0] page_word;
    bit          typed;
    logic [2:0]  status;
    logic [5:0]  page_type;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_word_index = '0;
  logic [31:0] in_page_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [5:0] out_page_type;
  logic out_param_valid;
  logic [4:0] out_param_id;
  logic signed [32:0] out_param_value;
  logic out_last;
  logic cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = '0;

  always #4 clk = ~clk;

  gnss_inav_page_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_word_index(in_word_index), .in_page_word(in_page_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_page_type(out_page_type),
    .out_param_valid(out_param_valid), .out_param_id(out_param_id),
    .out_param_value(out_param_value), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state.
  logic [31:0] pair_words [PAGE_WORDS];
  logic [5:0]  have_types;
  logic [9:0]  iod_seen [4];
  logic [31:0] raw_store [PARAM_COUNT];
  logic [5:0]  sat_id;
  nav_result_t expected_results [$];

  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int complete_sets = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit long_hold = 1'b0;

  // Parameter table: word type, data bit position, length, signedness.
  int tbl_type [PARAM_COUNT] = '{0,0,0,1,1,1,1,1,2,2,2,2,3,3,3,3,3,3,4,4,4,4,4,4,5,5,5,5,5,5};
  int tbl_pos [PARAM_COUNT] = '{96,108,6,6,16,30,62,94,16,48,80,112,16,40,56,72,88,104,
                                22,38,54,68,99,120,47,57,67,69,71,72};
  int tbl_len [PARAM_COUNT] = '{12,20,2,10,14,32,32,32,32,32,32,14,24,16,16,16,16,16,
                                16,16,14,31,21,6,10,10,2,2,1,1};
  bit tbl_sgn [PARAM_COUNT] = '{0,0,0,0,0,1,0,0,1,1,1,1,1,1,1,1,1,1,1,1,0,1,1,1,1,1,0,0,0,0};

  function automatic logic pair_bit(int pos);
    return pair_words[(pos >> 5) & 7][31 - (pos & 31)];
  endfunction

  function automatic logic [31:0] data_field(int pos, int len);
    logic [31:0] v;
    int d;
    v = '0;
    for (int i = 0; i < len; i++) begin
      d = (pos + i) & 127;
      v = {v[30:0], (d < 112) ? pair_bit(d + 2) : pair_bit(d + 18)};
    end
    return v;
  endfunction

  function automatic logic [23:0] pair_crc();
    logic [23:0] crc;
    logic b, top;
    crc = '0;
    for (int i = 0; i < 200; i++) begin
      if (i < 4) b = 1'b0;
      else if (i < 118) b = pair_bit(i - 4);
      else b = pair_bit(128 + i - 118);
      top = crc[23] ^ b;
      crc = {crc[22:0], 1'b0};
      if (top) crc ^= CRC_POLY;
    end
    return crc;
  endfunction

  function automatic logic [23:0] pair_crc_field();
    logic [23:0] v;
    v = '0;
    for (int i = 0; i < 24; i++) v = {v[22:0], pair_bit(210 + i)};
    return v;
  endfunction

  function automatic logic signed [32:0] ephemeris_value(int p);
    longint v, dt;
    v = raw_store[p];
    if (p == 0) begin
      dt = longint'(raw_store[4]) * 60 - longint'(raw_store[1]);
      if (dt > HALF_WEEK_S) v -= 1;
      else if (dt < -HALF_WEEK_S) v += 1;
      return 33'(v + WEEK_ROLL);
    end
    if (tbl_sgn[p] && raw_store[p][tbl_len[p] - 1]) v -= longint'(1) << tbl_len[p];
    return 33'(v);
  endfunction

  function automatic void push_status(logic [2:0] st, logic [5:0] ty, logic lst);
    nav_result_t r;
    r = '{status: st, page_type: ty, param_valid: 1'b0, param_id: '0, param_value: '0,
          last: lst};
    expected_results.push_back(r);
  endfunction

  // Works out the results of one accepted word.
  function automatic void decode_word(logic [2:0] idx, logic [31:0] w);
    logic [5:0] ty;
    nav_result_t r;
    pair_words[idx] = w;
    if (idx != 3'd7) return;
    if (pair_bit(1) || pair_bit(129)) begin push_status(ST_ALERT, '0, 1'b1); return; end
    if (pair_bit(0) != 1'b0 || pair_bit(128) != 1'b1) begin
      push_status(ST_EVEN_ODD, '0, 1'b1);
      return;
    end
    if (pair_crc() != pair_crc_field()) begin push_status(ST_CRC, '0, 1'b1); return; end
    ty = '0;
    for (int i = 0; i < 6; i++) ty = {ty[4:0], pair_bit(2 + i)};
    if (ty > 6'd5) begin push_status(ST_UNUSED, ty, 1'b1); return; end
    if (ty == 6'd2) have_types = '0;
    for (int p = 0; p < PARAM_COUNT; p++)
      if (tbl_type[p] == ty) raw_store[p] = data_field(tbl_pos[p], tbl_len[p]);
    if (ty >= 1 && ty <= 4) iod_seen[ty - 1] = 10'(data_field(6, 10));
    if (ty == 6'd4 && 6'(data_field(16, 6)) != sat_id) begin
      push_status(ST_SVID, ty, 1'b1);
      return;
    end
    have_types |= 6'(1 << ty);
    if (have_types != ALL_TYPES) begin push_status(ST_STORED, ty, 1'b1); return; end
    if (iod_seen[0] != iod_seen[1] || iod_seen[0] != iod_seen[2] ||
        iod_seen[0] != iod_seen[3]) begin
      push_status(ST_IOD, ty, 1'b1);
      return;
    end
    push_status(ST_COMPLETE, ty, 1'b0);
    for (int p = 0; p < PARAM_COUNT; p++) begin
      r = '{status: ST_COMPLETE, page_type: ty, param_valid: 1'b1, param_id: 5'(p),
            param_value: ephemeris_value(p), last: (p == PARAM_COUNT - 1)};
      expected_results.push_back(r);
    end
  endfunction

  // Builds a page pair: sets data bits, type, marks and a correct or broken CRC.
  logic [127:0] page_data;

  function automatic void set_data(int pos, int len, logic [31:0] v);
    for (int i = 0; i < len; i++) page_data[127 - ((pos + i) & 127)] = v[len - 1 - i];
  endfunction

  function automatic void build_pair(output logic [31:0] words [PAGE_WORDS],
                                     input bit alert, input bit bad_marks, input bit bad_crc);
    logic [255:0] s;
    logic [23:0] crc;
    logic b, top;
    for (int i = 0; i < PAGE_WORDS; i++) s[255 - 32 * i -: 32] = {$urandom};
    for (int d = 0; d < 128; d++) begin
      if (d < 112) s[255 - (d + 2)] = page_data[127 - d];
      else s[255 - (d + 18)] = page_data[127 - d];
    end
    s[255 - 0] = bad_marks ? 1'b1 : 1'b0;
    s[255 - 128] = 1'b1;
    if (bad_marks && $urandom_range(0, 1)) begin
      s[255 - 0] = 1'b0;
      s[255 - 128] = 1'b0;
    end
    s[255 - 1] = alert;
    s[255 - 129] = 1'b0;
    if (alert && $urandom_range(0, 1)) begin
      s[255 - 1] = $urandom_range(0, 1);
      s[255 - 129] = ~s[255 - 1] | $urandom_range(0, 1);
    end
    crc = '0;
    for (int i = 0; i < 200; i++) begin
      if (i < 4) b = 1'b0;
      else if (i < 118) b = s[255 - (i - 4)];
      else b = s[255 - (128 + i - 118)];
      top = crc[23] ^ b;
      crc = {crc[22:0], 1'b0};
      if (top) crc ^= CRC_POLY;
    end
    if (bad_crc) crc ^= 24'(1 << $urandom_range(0, 23));
    for (int i = 0; i < 24; i++) s[255 - (210 + i)] = crc[23 - i];
    for (int i = 0; i < PAGE_WORDS; i++) words[i] = s[255 - 32 * i -: 32];
  endfunction

  // Random data for a word type with a chosen iod and satellite id.
  function automatic void fill_data(int ty, logic [9:0] iod, logic [5:0] sv);
    page_data = {$urandom, $urandom, $urandom, $urandom};
    set_data(0, 6, 32'(ty));
    if (ty >= 1 && ty <= 4) set_data(6, 10, 32'(iod));
    if (ty == 4) set_data(16, 6, 32'(sv));
  endfunction

  // Sends one word through the input handshake; valid stays up for a following word.
  task automatic send_word(logic [2:0] idx, logic [31:0] w);
    int gap;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word_index <= idx;
    in_page_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(idx, w);
    words_sent++;
  endtask

  task automatic send_pair(logic [31:0] words [PAGE_WORDS]);
    for (int i = 0; i < PAGE_WORDS; i++) send_word(3'(i), words[i]);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sat_id(logic [5:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sat_id = v;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
  endtask

  // Checks every accepted result word against the oldest expectation.
  always @(posedge clk) begin
    nav_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("unexpected result word %0d, status %0d", results_seen, out_status);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_page_type !== e.page_type)
          report_mismatch("page_type", out_page_type, e.page_type);
        if (out_param_valid !== e.param_valid)
          report_mismatch("param_valid", out_param_valid, e.param_valid);
        if (out_param_id !== e.param_id) report_mismatch("param_id", out_param_id, e.param_id);
        if (out_param_value !== e.param_value)
          report_mismatch("param_value", out_param_value, e.param_value);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
        if (e.last && e.status == ST_COMPLETE) complete_sets++;
      end
    end
  end

  // Receiver stalls in random bursts, plus one long hold-off.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog expired with %0d results pending", expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends a set of types 0..5 with random content; spoil_iod alters the iod of type 3.
  task automatic send_full_set(logic [9:0] iod, bit spoil_iod);
    logic [31:0] words [PAGE_WORDS];
    int order [6] = '{2, 0, 1, 3, 4, 5};
    for (int k = 0; k < 6; k++) begin
      fill_data(order[k], (spoil_iod && order[k] == 3) ? iod ^ 10'd1 : iod, sat_id);
      build_pair(words, 1'b0, 1'b0, 1'b0);
      send_pair(words);
    end
  endtask

  // Sends a table row whose expectation was typed in by hand.
  task automatic send_raw_typed(stim_row_t r);
    in_valid <= 1'b1;
    in_word_index <= r.word_index;
    in_page_word <= r.page_word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    logic [31:0] words [PAGE_WORDS];
    int kind;
    int ty;
    logic [9:0] iod;
    for (int i = 0; i < PAGE_WORDS; i++) pair_words[i] = '0;
    have_types = '0;
    sat_id = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes of the word fields, alert, marks and CRC.
    for (int i = 0; i < PAGE_WORDS; i++) begin
      row = '{word_index: 3'(i), page_word: 32'hFFFF_FFFF, typed: (i == 7),
              status: ST_ALERT, page_type: '0};
      rows.push_back(row);
    end
    for (int i = 0; i < PAGE_WORDS; i++) begin
      row = '{word_index: 3'(i), page_word: '0, typed: (i == 7),
              status: ST_EVEN_ODD, page_type: '0};
      rows.push_back(row);
    end
    // Marks right, patterned data and CRC field; the predictor decides the status.
    for (int i = 0; i < PAGE_WORDS; i++) begin
      row = '{word_index: 3'(i), page_word: (i == 4) ? 32'h8000_0000 : 32'h2AAA_AAAA,
              typed: 1'b0, status: '0, page_type: '0};
      rows.push_back(row);
    end
    foreach (rows[i]) begin
      if (rows[i].typed)
        push_status(rows[i].status, rows[i].page_type, 1'b1);
      pair_words[rows[i].word_index] = rows[i].page_word;
      if (rows[i].typed) begin
        send_raw_typed(rows[i]);
      end else begin
        send_word(rows[i].word_index, rows[i].page_word);
      end
    end

    // Unused type 63 with a good CRC.
    fill_data(63, 10'd0, 6'd0);
    build_pair(words, 1'b0, 1'b0, 1'b0);
    send_pair(words);
    wait_quiet();

    // Full set under the two extreme satellite ids.
    for (int c = 0; c < 2; c++) begin
      write_sat_id(c == 0 ? 6'd0 : 6'd63);
      send_full_set(10'($urandom), 1'b0);
      // A mismatching satellite id on a type 4 page.
      fill_data(4, 10'd5, sat_id ^ 6'd1);
      build_pair(words, 1'b0, 1'b0, 1'b0);
      send_pair(words);
      wait_quiet();
    end
    send_full_set(10'h3FF, 1'b1);

    // Long hold on the receiver while pages keep coming.
    long_hold = 1'b1;
    send_full_set(10'($urandom), 1'b0);

    // Random pages: mostly well-formed sets and pages, some noise.
    while (words_sent < 380) begin
      if (words_sent > 330) quiet_phase = 1'b1;
      kind = $urandom_range(0, 9);
      iod = 10'($urandom);
      if (kind < 3) begin
        send_full_set(iod, $urandom_range(0, 4) == 0);
      end else if (kind < 8) begin
        ty = $urandom_range(0, 7);
        fill_data(ty, iod, ($urandom_range(0, 3) == 0) ? 6'($urandom) : sat_id);
        build_pair(words, kind == 7 && $urandom_range(0, 1), 1'b0, kind == 7);
        send_pair(words);
      end else begin
        send_word(3'($urandom), $urandom);
      end
      if (!quiet_phase && $urandom_range(0, 30) == 0) begin
        // Pending results drain before the satellite id is changed.
        wait_quiet();
        write_sat_id(6'($urandom));
      end
    end
    wait_quiet();

    $display("Sent %0d words, checked %0d results including %0d complete parameter sets.",
             words_sent, results_seen, complete_sets);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### gnss_inav_page_decoder.f
hdl/gipd_pkg.sv
hdl/gipd_ram.sv
hdl/gnss_inav_page_decoder.sv
test/gnss_inav_page_decoder_test.sv
